/* rtl/core/pmq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pmq_pkg;
   localparam int QueueSlots = 16;
   localparam int KernelPortBase = 4097;
   localparam int KernelPortCount = 6;
   localparam int UserPortBase = 8192;
   localparam int UserPortCount = 16;
   localparam int NumQueues = KernelPortCount + UserPortCount;
   localparam int SlotW = $clog2(QueueSlots);
   localparam int QueueW = $clog2(NumQueues);
   localparam int UserW = (UserPortCount > 1) ? $clog2(UserPortCount) : 1;
   localparam int FillW = $clog2(QueueSlots + 1);
   localparam int MemDepth = NumQueues * QueueSlots;
   localparam int AddrW = $clog2(MemDepth);
   localparam int MsgW = 16 + 16 + 32 * 6;

   typedef enum logic [2:0] {
      KIND_POST = 3'd0, KIND_KRECV = 3'd1, KIND_BIND = 3'd2,
      KIND_SEND = 3'd3, KIND_URECV = 3'd4, KIND_DEPTH = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_BAD = 2'd1, ST_FULL = 2'd2, ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0, ACT_ENQ = 2'd1, ACT_DEQ = 2'd2, ACT_BIND = 2'd3
   } act_type;

   typedef enum logic [1:0] {
      BE_IDLE = 2'd0, BE_READ = 2'd1, BE_OUT = 2'd2
   } be_state_type;

   typedef struct packed {
      logic [15:0] src;
      logic [15:0] dst;
      logic [31:0] opcode;
      logic [31:0] token;
      logic [31:0] p0;
      logic [31:0] p1;
      logic [31:0] p2;
      logic [31:0] p3;
   } msg_type;

   // Classified command handed from the front to the back.
   typedef struct packed {
      act_type act;
      logic has_q;
      logic [QueueW-1:0] q;
      logic user;
      logic [UserW-1:0] uidx;
      logic chk_part;
      status_type fail_status;
      logic [31:0] pid;
      logic [7:0] part;
      msg_type msg;
   } cmd_type;
endpackage
`default_nettype wire

/* rtl/core/pmq_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface pmq_req_if;
   logic valid;
   logic ready;
   logic [2:0] kind;
   logic [15:0] port_number;
   logic [31:0] requester_pid;
   logic [7:0] requester_partition;
   logic [15:0] source_port;
   logic [31:0] message_opcode;
   logic [31:0] message_token;
   logic [31:0] payload_word0;
   logic [31:0] payload_word1;
   logic [31:0] payload_word2;
   logic [31:0] payload_word3;
   modport source (output valid, kind, port_number, requester_pid, requester_partition,
      source_port, message_opcode, message_token, payload_word0, payload_word1,
      payload_word2, payload_word3, input ready);
   modport sink (input valid, kind, port_number, requester_pid, requester_partition,
      source_port, message_opcode, message_token, payload_word0, payload_word1,
      payload_word2, payload_word3, output ready);
endinterface

interface pmq_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] status;
   logic [15:0] out_source_port;
   logic [15:0] out_dest_port;
   logic [31:0] out_opcode;
   logic [31:0] out_token;
   logic [31:0] out_payload0;
   logic [31:0] out_payload1;
   logic [31:0] out_payload2;
   logic [31:0] out_payload3;
   logic [4:0] queue_fill;
   modport source (output valid, status, out_source_port, out_dest_port, out_opcode,
      out_token, out_payload0, out_payload1, out_payload2, out_payload3, queue_fill,
      input ready);
   modport sink (input valid, status, out_source_port, out_dest_port, out_opcode,
      out_token, out_payload0, out_payload1, out_payload2, out_payload3, queue_fill,
      output ready);
endinterface
`default_nettype wire

/* rtl/core/port_mailbox_queue_engine_unit.sv */
// Message mailbox with one ring queue per port (six kernel ports, sixteen user
// ports, sixteen messages each). The front classifies each request transaction
// and places it in a two-entry command queue; the back executes one command at
// a time: it takes the command, updates the queue state while reading the
// message memory, and then holds a registered response until the consumer
// takes it. The back takes no new command before its response was taken; the
// command queue holds up to two further requests meanwhile. Message storage
// is not cleared after reset; its contents reach a response only after they
// were written.
`timescale 1ns / 1ps
`default_nettype none
module port_mailbox_queue_engine_unit (
   input wire logic clock,
   input wire logic reset,
   pmq_req_if.sink req,
   pmq_rsp_if.source rsp
);
   import pmq_pkg::*;
   cmd_type f_cmd, b_cmd;
   logic f_valid, f_ready, b_valid, b_ready;

   pmq_front u_front (.req(req), .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd));
   pmq_cmd_fifo u_fifo (.clock(clock), .reset(reset), .in_valid(f_valid),
      .in_ready(f_ready), .in_cmd(f_cmd), .out_valid(b_valid), .out_ready(b_ready),
      .out_cmd(b_cmd));
   pmq_back u_back (.clock(clock), .reset(reset), .cmd_valid(b_valid),
      .cmd_ready(b_ready), .cmd(b_cmd), .rsp(rsp));
endmodule
`default_nettype wire

/* rtl/core/pmq_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module pmq_front (
   pmq_req_if.sink req,
   output logic cmd_valid,
   input wire logic cmd_ready,
   output pmq_pkg::cmd_type cmd
);
   import pmq_pkg::*;
   logic k_hit, u_hit;
   logic [16:0] k_off, u_off;

   assign req.ready = cmd_ready;
   assign cmd_valid = req.valid;
   assign k_off = {1'b0, req.port_number} - 17'(KernelPortBase);
   assign u_off = {1'b0, req.port_number} - 17'(UserPortBase);
   assign k_hit = !k_off[16] && (k_off < 17'(KernelPortCount));
   assign u_hit = !u_off[16] && (u_off < 17'(UserPortCount));

   always_comb begin
      cmd = '0;
      cmd.act = ACT_NONE;
      cmd.fail_status = ST_BAD;
      cmd.uidx = u_off[UserW-1:0];
      cmd.pid = req.requester_pid;
      cmd.part = req.requester_partition;
      cmd.msg.src = req.source_port;
      cmd.msg.dst = req.port_number;
      cmd.msg.opcode = req.message_opcode;
      cmd.msg.token = req.message_token;
      cmd.msg.p0 = req.payload_word0;
      cmd.msg.p1 = req.payload_word1;
      cmd.msg.p2 = req.payload_word2;
      cmd.msg.p3 = req.payload_word3;
      if (k_hit) begin
         cmd.q = QueueW'(k_off);
      end else begin
         cmd.q = QueueW'(KernelPortCount) + QueueW'(u_off);
      end
      unique case (req.kind)
         KIND_POST: begin
            if (k_hit) begin cmd.act = ACT_ENQ; cmd.has_q = 1'b1; end
         end
         KIND_KRECV: begin
            cmd.fail_status = ST_EMPTY;
            if (k_hit) begin cmd.act = ACT_DEQ; cmd.has_q = 1'b1; end
         end
         KIND_BIND: begin
            if (u_hit) begin
               cmd.act = ACT_BIND; cmd.has_q = 1'b1; cmd.user = 1'b1;
            end
         end
         KIND_SEND: begin
            cmd.msg.src = req.requester_pid[15:0];
            cmd.msg.token = '0;
            if (k_hit) begin
               cmd.act = ACT_ENQ; cmd.has_q = 1'b1;
            end else if (u_hit) begin
               cmd.act = ACT_ENQ; cmd.has_q = 1'b1; cmd.user = 1'b1;
               cmd.chk_part = 1'b1;
            end
         end
         KIND_URECV: begin
            cmd.fail_status = ST_EMPTY;
            if (u_hit) begin
               cmd.q = QueueW'(KernelPortCount) + QueueW'(u_off);
               cmd.act = ACT_DEQ; cmd.has_q = 1'b1; cmd.user = 1'b1;
               cmd.chk_part = 1'b1;
            end
         end
         KIND_DEPTH: begin
            if (k_hit) cmd.has_q = 1'b1;
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

/* rtl/core/pmq_cmd_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
module pmq_cmd_fifo (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input pmq_pkg::cmd_type in_cmd,
   output logic out_valid,
   input wire logic out_ready,
   output pmq_pkg::cmd_type out_cmd
);
   import pmq_pkg::*;
   cmd_type entry_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_cmd = entry_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) entry_ff[wp_ff] <= in_cmd;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule
`default_nettype wire

/* rtl/core/pmq_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module pmq_back (
   input wire logic clock,
   input wire logic reset,
   input wire logic cmd_valid,
   output logic cmd_ready,
   input pmq_pkg::cmd_type cmd,
   pmq_rsp_if.source rsp
);
   import pmq_pkg::*;
   msg_type mem [MemDepth];
   msg_type rd_ff;
   logic [SlotW-1:0] rptr_ff [NumQueues];
   logic [SlotW-1:0] wptr_ff [NumQueues];
   logic [FillW-1:0] fill_ff [NumQueues];
   logic [31:0] opid_ff [UserPortCount];
   logic [7:0] opart_ff [UserPortCount];
   logic [31:0] posted_ff, dispatched_ff, dropped_ff;
   be_state_type state_ff, state_in;
   cmd_type cur_ff;
   status_type st_ff, st_in;
   logic [FillW-1:0] qf_ff, qf_in;
   logic give_ff, give_in;
   logic take, denied, bound, do_enq, do_deq, do_bind;
   logic [FillW-1:0] fill;
   logic [AddrW-1:0] waddr, raddr;

   assign take = cmd_valid && cmd_ready;
   assign fill = fill_ff[cur_ff.q];
   assign bound = opid_ff[cur_ff.uidx] != '0;
   assign denied = cur_ff.chk_part && bound && opart_ff[cur_ff.uidx] != cur_ff.part;
   assign waddr = AddrW'(cur_ff.q) * AddrW'(QueueSlots) + AddrW'(wptr_ff[cur_ff.q]);
   assign raddr = AddrW'(cur_ff.q) * AddrW'(QueueSlots) + AddrW'(rptr_ff[cur_ff.q]);

   always_comb begin
      state_in = state_ff;
      cmd_ready = 1'b0;
      st_in = st_ff; qf_in = qf_ff; give_in = give_ff;
      do_enq = 1'b0; do_deq = 1'b0; do_bind = 1'b0;
      unique case (state_ff)
         BE_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) state_in = BE_READ;
         end
         BE_READ: begin
            // Decide, update the queue state and read the slot in one step.
            state_in = BE_OUT;
            give_in = 1'b0;
            st_in = cur_ff.fail_status;
            qf_in = cur_ff.has_q ? fill : '0;
            unique case (cur_ff.act)
               ACT_ENQ: begin
                  if (denied) begin
                     qf_in = '0;
                  end else if (fill >= FillW'(QueueSlots)) begin
                     st_in = ST_FULL; do_enq = 1'b0;
                  end else begin
                     st_in = ST_OK; do_enq = 1'b1; qf_in = fill + 1'b1;
                  end
               end
               ACT_DEQ: begin
                  if (denied) begin
                     qf_in = '0;
                  end else if (fill != '0) begin
                     st_in = ST_OK; do_deq = 1'b1; give_in = 1'b1;
                     qf_in = fill - 1'b1;
                  end
               end
               ACT_BIND: begin
                  if (bound && opid_ff[cur_ff.uidx] != cur_ff.pid) begin
                     st_in = ST_FULL;
                  end else begin
                     st_in = ST_OK; do_bind = 1'b1;
                  end
               end
               ACT_NONE: begin
                  if (cur_ff.has_q) st_in = ST_OK;
               end
               default: ;
            endcase
         end
         BE_OUT: begin
            if (rsp.ready) state_in = BE_IDLE;
         end
         default: state_in = BE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (take) cur_ff <= cmd;
      if (do_enq) mem[waddr] <= cur_ff.msg;
      // The read slot is captured once so that it holds while the response waits.
      if (state_ff == BE_READ) rd_ff <= mem[raddr];
      if (state_ff == BE_READ) begin
         st_ff <= st_in; qf_ff <= qf_in; give_ff <= give_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BE_IDLE;
         posted_ff <= '0; dispatched_ff <= '0; dropped_ff <= '0;
         for (int i = 0; i < NumQueues; i++) begin
            rptr_ff[i] <= '0; wptr_ff[i] <= '0; fill_ff[i] <= '0;
         end
         for (int i = 0; i < UserPortCount; i++) begin
            opid_ff[i] <= '0; opart_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (do_bind) begin
            opid_ff[cur_ff.uidx] <= cur_ff.pid;
            opart_ff[cur_ff.uidx] <= cur_ff.part;
         end
         if (do_enq) begin
            wptr_ff[cur_ff.q] <= wptr_ff[cur_ff.q] + 1'b1;
            fill_ff[cur_ff.q] <= fill + 1'b1;
            posted_ff <= posted_ff + 1'b1;
         end
         if (state_ff == BE_READ && cur_ff.act == ACT_ENQ && !denied &&
             fill >= FillW'(QueueSlots)) dropped_ff <= dropped_ff + 1'b1;
         if (do_deq) begin
            rptr_ff[cur_ff.q] <= rptr_ff[cur_ff.q] + 1'b1;
            fill_ff[cur_ff.q] <= fill - 1'b1;
            dispatched_ff <= dispatched_ff + 1'b1;
         end
      end
   end

   assign rsp.valid = state_ff == BE_OUT;
   assign rsp.status = st_ff;
   assign rsp.queue_fill = qf_ff;
   assign rsp.out_source_port = give_ff ? rd_ff.src : '0;
   assign rsp.out_dest_port = give_ff ? rd_ff.dst : '0;
   assign rsp.out_opcode = give_ff ? rd_ff.opcode : '0;
   assign rsp.out_token = give_ff ? rd_ff.token : '0;
   assign rsp.out_payload0 = give_ff ? rd_ff.p0 : '0;
   assign rsp.out_payload1 = give_ff ? rd_ff.p1 : '0;
   assign rsp.out_payload2 = give_ff ? rd_ff.p2 : '0;
   assign rsp.out_payload3 = give_ff ? rd_ff.p3 : '0;
endmodule
`default_nettype wire

/* rtl/core/pmq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module pmq_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [1:0] rsp_status,
   input wire logic [4:0] rsp_fill,
   input wire logic [31:0] rsp_opcode
);
   import pmq_pkg::*;
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped while stalled");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fill <= 5'(QueueSlots))
      else $error("fill out of range");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_opcode == '0)
      else $error("message fields on failure");
endmodule

bind port_mailbox_queue_engine_unit pmq_checker u_chk (.clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
   .rsp_fill(rsp.queue_fill), .rsp_opcode(rsp.out_opcode));
`default_nettype wire
